>>> src/tfr_pkg.sv
`default_nettype none
package tfr_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_ENQ = 2'd0,
		REQ_DEQ = 2'd1,
		REQ_REM = 2'd2,
		REQ_CLR = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned TAG_W     = 32;
	localparam int unsigned COUNT_W   = 5;

	// contents of one queue slot
	typedef struct packed {
		logic                 valid;
		logic [PAYLOAD_W-1:0] payload;
		logic [TAG_W-1:0]     tag;
	} slot_t;

	// request broadcast to every cell
	typedef struct packed {
		logic                 go;
		req_t                 op;
		logic [PAYLOAD_W-1:0] payload;
		logic [TAG_W-1:0]     new_tag;
		logic [TAG_W-1:0]     want;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> src/tagged_fifo_with_remove.sv
// Ordered queue of QUEUE_DEPTH tagged 64-bit entries.
// Input channel (in_valid / in_stall) carries req_type, payload_in and tag_in:
// enqueue appends payload_in and returns a fresh tag from a wrapping 32-bit
// counter, dequeue pops the oldest entry, remove deletes the oldest entry
// whose tag equals tag_in and closes the gap, clear empties the queue.
// Every request gives one result on the output channel (out_valid /
// out_stall): status, payload_out, tag_out and entry_count after the request.
// The slots form a chain of cells that compare all tags at once and shift
// toward the head together, so a result appears in the output register the
// cycle after the transfer, and one request per cycle is sustained while the
// output is taken.
// The output register holds its result while out_stall is high; in that time
// in_stall is raised and no new request is taken.
// Reset empties the queue, zeroes the tag counter and drops any pending
// result; slot contents are not cleared, only their valid bits.
`default_nettype none
module tagged_fifo_with_remove #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [1:0]  req_type,
	input  wire [63:0] payload_in,
	input  wire [31:0] tag_in,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] status,
	output logic [63:0] payload_out,
	output logic [31:0] tag_out,
	output logic [4:0] entry_count
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	tfr_pkg::slot_t        slots [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH:0]  hits;
	tfr_pkg::cell_ctrl_t   ctrl;
	tfr_pkg::req_t         op;
	logic                  accept;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [31:0]           next_tag_q;
	logic                  full;
	logic                  empty;
	logic                  found;
	logic [CW+4:0]         count_ext;
	tfr_pkg::status_t      status_d;
	logic [63:0]           payload_d;
	logic [31:0]           tag_d;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [63:0]           payload_q;
	logic [31:0]           tag_q;
	logic [4:0]            count_out_q;

	assign op       = tfr_pkg::req_t'(req_type);
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign found = hits[QUEUE_DEPTH];

	// request broadcast
	assign ctrl.go      = accept;
	assign ctrl.op      = op;
	assign ctrl.payload = payload_in;
	assign ctrl.new_tag = next_tag_q;
	assign ctrl.want    = tag_in;

	// cell chain, slot 0 is the head
	assign hits[0]            = 1'b0;
	assign slots[QUEUE_DEPTH] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic prv_valid;
		if (i == 0) begin : g_head
			assign prv_valid = 1'b1;
		end else begin : g_body
			assign prv_valid = slots[i-1].valid;
		end
		tfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.prv_valid (prv_valid),
			.nxt       (slots[i+1]),
			.hit_in    (hits[i]),
			.cur       (slots[i]),
			.hit_out   (hits[i+1])
		);
	end

	// result and count update
	always_comb begin
		status_d  = tfr_pkg::ST_OK;
		payload_d = '0;
		tag_d     = '0;
		count_d   = count_q;
		unique case (op)
			tfr_pkg::REQ_ENQ: begin
				if (full) begin
					status_d = tfr_pkg::ST_FULL;
				end else begin
					tag_d   = next_tag_q;
					count_d = count_q + CW'(1);
				end
			end
			tfr_pkg::REQ_DEQ: begin
				if (empty) begin
					status_d = tfr_pkg::ST_EMPTY;
				end else begin
					payload_d = slots[0].payload;
					count_d   = count_q - CW'(1);
				end
			end
			tfr_pkg::REQ_REM: begin
				if (found)
					count_d = count_q - CW'(1);
				else
					status_d = tfr_pkg::ST_EMPTY;
			end
			tfr_pkg::REQ_CLR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {5'd0, count_d};

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			next_tag_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
			if (op == tfr_pkg::REQ_ENQ && !full)
				next_tag_q <= next_tag_q + 32'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			payload_q   <= payload_d;
			tag_q       <= tag_d;
			count_out_q <= count_ext[4:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign payload_out = payload_q;
	assign tag_out     = tag_q;
	assign entry_count = count_out_q;

endmodule
`default_nettype wire

>>> src/tfr_cell.sv
`default_nettype none
module tfr_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tfr_pkg::cell_ctrl_t ctrl,
	input  wire                 prv_valid,
	input  tfr_pkg::slot_t      nxt,
	input  wire                 hit_in,
	output tfr_pkg::slot_t      cur,
	output logic                hit_out
);

	logic                          valid_q;
	logic [tfr_pkg::PAYLOAD_W-1:0] payload_q;
	logic [tfr_pkg::TAG_W-1:0]     tag_q;
	logic                          load;
	logic                          shift;
	logic                          valid_d;

	assign cur.valid   = valid_q;
	assign cur.payload = payload_q;
	assign cur.tag     = tag_q;

	// oldest-match chain: a hit here or below shifts this slot on remove
	assign hit_out = hit_in | (valid_q && (tag_q == ctrl.want));

	// slot action for the broadcast request
	always_comb begin
		load    = 1'b0;
		shift   = 1'b0;
		valid_d = valid_q;
		if (ctrl.go) begin
			unique case (ctrl.op)
				tfr_pkg::REQ_ENQ: begin
					load = !valid_q && prv_valid;
				end
				tfr_pkg::REQ_DEQ: begin
					shift = 1'b1;
				end
				tfr_pkg::REQ_REM: begin
					shift = hit_out;
				end
				tfr_pkg::REQ_CLR: begin
					valid_d = 1'b0;
				end
				default: begin
				end
			endcase
			if (load)
				valid_d = 1'b1;
			else if (shift)
				valid_d = nxt.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_d;
	end

	// slot contents, no reset needed
	always_ff @(posedge clk) begin
		if (load) begin
			payload_q <= ctrl.payload;
			tag_q     <= ctrl.new_tag;
		end else if (shift) begin
			payload_q <= nxt.payload;
			tag_q     <= nxt.tag;
		end
	end

endmodule
`default_nettype wire

>>> dv/tagged_fifo_with_remove_test.sv
`timescale 1ns / 100ps

module tagged_fifo_with_remove_test;

	localparam int QUEUE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 1725;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_LIMIT  = 2000;

	// one stored queue entry in the predictor
	typedef struct {
		logic [63:0] payload;
		logic [31:0] tag;
	} stored_entry_t;

	// one result as seen on the output channel
	typedef struct {
		tfr_pkg::status_t status;
		logic [63:0]      payload;
		logic [31:0]      tag;
		logic [4:0]       count;
	} queue_result_t;

	// one request, with an optional hand-written expectation
	typedef struct {
		tfr_pkg::req_t op;
		logic [63:0]   payload;
		logic [31:0]   tag;
		bit            fixed_exp;
		queue_result_t res;
	} bench_row_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [1:0]  req_type    = 2'd0;
	logic [63:0] payload_in  = 64'd0;
	logic [31:0] tag_in      = 32'd0;
	logic        out_stall   = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [63:0] payload_out;
	logic [31:0] tag_out;
	logic [4:0]  entry_count;

	// predictor state
	stored_entry_t model_entries[$];
	logic [31:0]   model_next_tag = 32'd0;
	queue_result_t pending_results[$];

	bench_row_t directed_rows[$];
	bench_row_t cur_row;
	int         total_items;
	int         sent_count = 0;
	int         fail_count = 0;
	int         traffic_mode = 0;
	logic       hold_off = 1'b0;

	// coverage tallies
	int n_enq_ok, n_full, n_deq_ok, n_deq_empty, n_rem_hit, n_rem_miss, n_clr;

	tagged_fifo_with_remove #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.payload_in (payload_in),
		.tag_in     (tag_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.payload_out(payload_out),
		.tag_out    (tag_out),
		.entry_count(entry_count)
	);

	always #10 clk = ~clk;

	// predictor: apply one request to the model queue, return its result
	task automatic queue_model_step(input bench_row_t rq, output queue_result_t res);
		int            hit;
		stored_entry_t head;
		res.status  = tfr_pkg::ST_OK;
		res.payload = 64'd0;
		res.tag     = 32'd0;
		hit = -1;
		case (rq.op)
			tfr_pkg::REQ_ENQ: begin
				if (model_entries.size() >= QUEUE_DEPTH) begin
					res.status = tfr_pkg::ST_FULL;
					n_full++;
				end else begin
					model_entries.push_back('{rq.payload, model_next_tag});
					res.tag = model_next_tag;
					model_next_tag = model_next_tag + 32'd1;
					n_enq_ok++;
				end
			end
			tfr_pkg::REQ_DEQ: begin
				if (model_entries.size() == 0) begin
					res.status = tfr_pkg::ST_EMPTY;
					n_deq_empty++;
				end else begin
					head = model_entries.pop_front();
					res.payload = head.payload;
					n_deq_ok++;
				end
			end
			tfr_pkg::REQ_REM: begin
				// oldest match only
				for (int i = 0; i < model_entries.size(); i++) begin
					if (hit < 0 && model_entries[i].tag == rq.tag)
						hit = i;
				end
				if (hit < 0) begin
					res.status = tfr_pkg::ST_EMPTY;
					n_rem_miss++;
				end else begin
					model_entries.delete(hit);
					n_rem_hit++;
				end
			end
			default: begin
				model_entries.delete();
				n_clr++;
			end
		endcase
		res.count = 5'(model_entries.size());
	endtask

	task automatic add_row(input tfr_pkg::req_t op, input logic [63:0] pay,
			input logic [31:0] tg, input bit fixed_exp, input tfr_pkg::status_t st,
			input logic [63:0] pay_exp, input logic [31:0] tag_exp, input logic [4:0] cnt);
		bench_row_t row;
		row.op        = op;
		row.payload   = pay;
		row.tag       = tg;
		row.fixed_exp = fixed_exp;
		row.res       = '{st, pay_exp, tag_exp, cnt};
		directed_rows.push_back(row);
	endtask

	// next request: table first, then random traffic shaped by the model state
	task automatic pick_next_request(output bench_row_t row);
		int r;
		int rnd_idx;
		rnd_idx = sent_count - directed_rows.size();
		if (rnd_idx < 0) begin
			row = directed_rows[sent_count];
		end else begin
			if (rnd_idx % 48 == 0)
				traffic_mode = $urandom_range(2);
			r = $urandom_range(99);
			row.fixed_exp = 1'b0;
			row.res       = '{tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0};
			case (traffic_mode)
				0:       row.op = (r < 65) ? tfr_pkg::REQ_ENQ : (r < 75) ? tfr_pkg::REQ_DEQ :
						(r < 98) ? tfr_pkg::REQ_REM : tfr_pkg::REQ_CLR;
				1:       row.op = (r < 15) ? tfr_pkg::REQ_ENQ : (r < 70) ? tfr_pkg::REQ_DEQ :
						(r < 98) ? tfr_pkg::REQ_REM : tfr_pkg::REQ_CLR;
				default: row.op = (r < 40) ? tfr_pkg::REQ_ENQ : (r < 70) ? tfr_pkg::REQ_DEQ :
						(r < 97) ? tfr_pkg::REQ_REM : tfr_pkg::REQ_CLR;
			endcase
			row.payload = {$urandom, $urandom};
			r = $urandom_range(15);
			if (r == 0)
				row.payload = '1;
			else if (r == 1)
				row.payload = '0;
			row.tag = $urandom;
			// removes mostly aim at held or recently used tags
			if (row.op == tfr_pkg::REQ_REM) begin
				r = $urandom_range(99);
				if (r < 70 && model_entries.size() != 0)
					row.tag = model_entries[$urandom_range(model_entries.size() - 1)].tag;
				else if (r < 85)
					row.tag = model_next_tag - 32'd1 - 32'($urandom_range(40));
			end
		end
	endtask

	// directed table
	initial begin
		add_row(tfr_pkg::REQ_DEQ, 64'd0, 32'd0, 1, tfr_pkg::ST_EMPTY, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_REM, '1, 32'd0, 1, tfr_pkg::ST_EMPTY, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_CLR, '1, '1, 1, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_ENQ, '1, 32'd0, 1, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd1);
		add_row(tfr_pkg::REQ_ENQ, 64'd0, '1, 1, tfr_pkg::ST_OK, 64'd0, 32'd1, 5'd2);
		add_row(tfr_pkg::REQ_REM, 64'd0, '1, 1, tfr_pkg::ST_EMPTY, 64'd0, 32'd0, 5'd2);
		add_row(tfr_pkg::REQ_DEQ, 64'd0, 32'd0, 1, tfr_pkg::ST_OK, '1, 32'd0, 5'd1);
		// fill to the brim
		for (int i = 0; i < 15; i++)
			add_row(tfr_pkg::REQ_ENQ, 64'hA5C3_0F96_0000_0000 | 64'(i), 32'(i),
				0, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_ENQ, '1, 32'd0, 1, tfr_pkg::ST_FULL, 64'd0, 32'd0, 5'd16);
		// take one from the middle, then one from the head, order must hold
		add_row(tfr_pkg::REQ_REM, 64'd0, 32'd9, 0, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_REM, 64'd0, 32'd1, 0, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_DEQ, 64'd0, 32'd0, 0, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_CLR, 64'd0, 32'd0, 1, tfr_pkg::ST_OK, 64'd0, 32'd0, 5'd0);
		add_row(tfr_pkg::REQ_DEQ, 64'd0, 32'd0, 1, tfr_pkg::ST_EMPTY, 64'd0, 32'd0, 5'd0);
		total_items = directed_rows.size() + RANDOM_ITEMS;
	end

	// check results, predict accepted requests, drive both channels
	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_res;
		queue_result_t pred_res;
		bench_row_t    next_row;
		bit            steady;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			steady = (sent_count >= 800 && sent_count < 1100);

			// result transfer
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"ERROR: result with nothing expected: ",
							"status=%0d payload=%h tag=%h count=%0d"},
							status, payload_out, tag_out, entry_count);
				end else begin
					exp_res = pending_results.pop_front();
					if (status !== exp_res.status || payload_out !== exp_res.payload ||
							tag_out !== exp_res.tag || entry_count !== exp_res.count) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("ERROR: expected status=%0d payload=%h tag=%h count=%0d",
								exp_res.status, exp_res.payload, exp_res.tag, exp_res.count);
							$display("          got status=%0d payload=%h tag=%h count=%0d",
								status, payload_out, tag_out, entry_count);
						end
					end
				end
			end

			// request transfer
			if (in_valid && !in_stall) begin
				queue_model_step(cur_row, pred_res);
				pending_results.push_back(cur_row.fixed_exp ? cur_row.res : pred_res);
				sent_count++;
			end

			// present the next request once the current one is gone
			if (!in_valid || !in_stall) begin
				if (sent_count < total_items && (steady || $urandom_range(99) >= 11)) begin
					pick_next_request(next_row);
					cur_row    = next_row;
					in_valid   <= 1'b1;
					req_type   <= next_row.op;
					payload_in <= next_row.payload;
					tag_in     <= next_row.tag;
				end else begin
					in_valid <= 1'b0;
				end
			end

			out_stall <= hold_off || (!steady && $urandom_range(99) < 11);
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	initial begin
		wait (sent_count >= 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// reset, run, drain, report
	initial begin
		int wait_cycles;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (total_items > 0 && sent_count == total_items);
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			fail_count += pending_results.size();
			$display("ERROR: %0d results never arrived", pending_results.size());
		end
		$display("Ran %0d requests: %0d enqueued, %0d refused full, %0d popped, %0d empty pops",
			sent_count, n_enq_ok, n_full, n_deq_ok, n_deq_empty);
		$display("Removes: %0d found, %0d missed; %0d clears; %0d failures",
			n_rem_hit, n_rem_miss, n_clr, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("ERROR: timeout with %0d of %0d requests sent", sent_count, total_items);
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
src/tfr_pkg.sv
src/tfr_cell.sv
src/tagged_fifo_with_remove.sv
dv/tagged_fifo_with_remove_test.sv
